FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the multiresolution cell lookup.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define MCPL_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define MCPL_NEVER(lbl, clk_s, rstn_s, cond, msg) \
  `MCPL_ASSERT(lbl, clk_s, rstn_s, !(cond), msg)

`endif

FILE: rtl/mcpl_pkg.sv
// Package for the multiresolution cell lookup: command codes, status codes,
// fixed field widths and the result record. No dependencies.
`timescale 1ns / 1ps

package mcpl_pkg;

  localparam int LEVEL_W  = 5;
  localparam int VALUE_W  = 32;
  localparam int PCOORD_W = 16;
  localparam int PINDEX_W = 10;
  localparam int CMD_W    = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_t;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic                status;
    logic                found;
    logic [VALUE_W-1:0]  value;
    logic [LEVEL_W-1:0]  level;
    logic [PINDEX_W-1:0] index;
  } result_t;

endpackage

FILE: rtl/mcpl_load_fmt.sv
// Load formatting: saturates the level, applies the optional centre
// correction and snaps the corner to the level grid. Uses mcpl_pkg.
`timescale 1ns / 1ps

module mcpl_load_fmt #(
  parameter int COORD_BITS = 16
) (
  input  logic                         centre,
  input  logic [mcpl_pkg::LEVEL_W-1:0] level_in,
  input  logic [COORD_BITS-1:0]        cx,
  input  logic [COORD_BITS-1:0]        cy,
  input  logic [COORD_BITS-1:0]        cz,
  output logic [mcpl_pkg::LEVEL_W-1:0] level_out,
  output logic [COORD_BITS-1:0]        kx,
  output logic [COORD_BITS-1:0]        ky,
  output logic [COORD_BITS-1:0]        kz
);

  localparam logic [mcpl_pkg::LEVEL_W-1:0] LVL_MAX = mcpl_pkg::LEVEL_W'(COORD_BITS);
  localparam logic [COORD_BITS-1:0]        ONES    = '1;

  logic [mcpl_pkg::LEVEL_W-1:0] lvl;
  logic [mcpl_pkg::LEVEL_W-1:0] sh;
  logic [COORD_BITS-1:0]        mask;
  logic [COORD_BITS-1:0]        half;

  function automatic logic [COORD_BITS-1:0] snap(input logic [COORD_BITS-1:0] c,
                                                 input logic [COORD_BITS-1:0] h,
                                                 input logic [COORD_BITS-1:0] m);
    logic [COORD_BITS-1:0] d;
    d = (c >= h) ? (c - h) : '0;
    return d & m;
  endfunction

  always_comb begin
    lvl  = (level_in > LVL_MAX) ? LVL_MAX : level_in;
    sh   = LVL_MAX - lvl;
    mask = ONES << sh;
    half = '0;
    if (centre && (lvl < LVL_MAX)) begin
      half = COORD_BITS'(1) << (sh - mcpl_pkg::LEVEL_W'(1));
    end
  end

  assign level_out = lvl;
  assign kx = snap(cx, half, mask);
  assign ky = snap(cy, half, mask);
  assign kz = snap(cz, half, mask);

endmodule

FILE: rtl/mcpl_cell_match.sv
// Containment test of a query point against one stored cell key.
// Uses mcpl_pkg for the level width.
`timescale 1ns / 1ps

module mcpl_cell_match #(
  parameter int COORD_BITS = 16
) (
  input  logic [COORD_BITS-1:0]        qx,
  input  logic [COORD_BITS-1:0]        qy,
  input  logic [COORD_BITS-1:0]        qz,
  input  logic [mcpl_pkg::LEVEL_W-1:0] level,
  input  logic [COORD_BITS-1:0]        kx,
  input  logic [COORD_BITS-1:0]        ky,
  input  logic [COORD_BITS-1:0]        kz,
  output logic                         hit
);

  localparam logic [mcpl_pkg::LEVEL_W-1:0] LVL_MAX = mcpl_pkg::LEVEL_W'(COORD_BITS);
  localparam logic [COORD_BITS-1:0]        ONES    = '1;

  logic [COORD_BITS-1:0] mask;

  assign mask = ONES << (LVL_MAX - level);
  assign hit  = ((qx & mask) == kx) && ((qy & mask) == ky) && ((qz & mask) == kz);

endmodule

FILE: rtl/mcpl_cell_mem.sv
// Cell table storage: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module mcpl_cell_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 85
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/multires_cell_point_lookup.sv
// Multiresolution cell table with point lookup. Items are taken one at a time.
// A clear or load item goes from idle to the finish state, which registers its
// result before the next item can be taken. A lookup scans the stored cells one
// per cycle through the single read port of the cell memory, then passes the
// drain and finish states before its result is registered; on an empty table it
// goes straight to the finish state. A result not yet taken holds the next item
// back. The table needs no clearing pass: the fill count bounds every scan. Uses
// mcpl_pkg and the mcpl_* submodules.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module multires_cell_point_lookup #(
  parameter int TABLE_DEPTH = 1024,
  parameter int COORD_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mcpl_pkg::CMD_W-1:0]    in_command,
  input  logic [mcpl_pkg::PCOORD_W-1:0] in_coord_x,
  input  logic [mcpl_pkg::PCOORD_W-1:0] in_coord_y,
  input  logic [mcpl_pkg::PCOORD_W-1:0] in_coord_z,
  input  logic [mcpl_pkg::LEVEL_W-1:0]  in_cell_level,
  input  logic [mcpl_pkg::VALUE_W-1:0]  in_cell_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_status,
  output logic                          out_found,
  output logic [mcpl_pkg::VALUE_W-1:0]  out_found_value,
  output logic [mcpl_pkg::LEVEL_W-1:0]  out_found_level,
  output logic [mcpl_pkg::PINDEX_W-1:0] out_entry_index
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int LW    = mcpl_pkg::LEVEL_W;
  localparam int VW    = mcpl_pkg::VALUE_W;
  localparam int DW    = LW + 3 * COORD_BITS + VW;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_FIN} state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                centre_r;
  logic                out_valid_r, out_valid_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]       iss_r, iss_nxt;
  logic [AW-1:0]       rd_idx_r;
  logic [COORD_BITS-1:0] q_x_r, q_y_r, q_z_r;
  mcpl_pkg::result_t   res_r, res_nxt;
  mcpl_pkg::result_t   out_res_r, out_res_nxt;

  logic                  acc, full, last_iss, hit, mem_we;
  logic [COORD_BITS-1:0] in_x, in_y, in_z;
  logic [LW-1:0]         fmt_level;
  logic [COORD_BITS-1:0] fmt_x, fmt_y, fmt_z;
  logic [DW-1:0]         mem_wdata, mem_rdata;
  logic [LW-1:0]         rd_level;
  logic [COORD_BITS-1:0] rd_x, rd_y, rd_z;
  logic [VW-1:0]         rd_value;

  assign in_x     = COORD_BITS'(in_coord_x);
  assign in_y     = COORD_BITS'(in_coord_y);
  assign in_z     = COORD_BITS'(in_coord_z);
  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid && in_ready;
  assign full     = (cnt_r == CNT_FULL);
  assign last_iss = ((CNT_W'(iss_r) + CNT_W'(1)) == cnt_r);
  assign mem_we   = acc && (mcpl_pkg::cmd_t'(in_command) == mcpl_pkg::CMD_LOAD) && !full;

  mcpl_load_fmt #(.COORD_BITS(COORD_BITS)) u_fmt (
    .centre    (centre_r),
    .level_in  (in_cell_level),
    .cx        (in_x),
    .cy        (in_y),
    .cz        (in_z),
    .level_out (fmt_level),
    .kx        (fmt_x),
    .ky        (fmt_y),
    .kz        (fmt_z)
  );

  assign mem_wdata = {fmt_level, fmt_x, fmt_y, fmt_z, in_cell_value};

  mcpl_cell_mem #(.DEPTH(TABLE_DEPTH), .AW(AW), .DW(DW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (mem_wdata),
    .re    (state_r == S_SCAN),
    .raddr (iss_r),
    .rdata (mem_rdata)
  );

  assign rd_level = mem_rdata[DW-1 -: LW];
  assign rd_x     = mem_rdata[VW+3*COORD_BITS-1 -: COORD_BITS];
  assign rd_y     = mem_rdata[VW+2*COORD_BITS-1 -: COORD_BITS];
  assign rd_z     = mem_rdata[VW+COORD_BITS-1 -: COORD_BITS];
  assign rd_value = mem_rdata[VW-1:0];

  mcpl_cell_match #(.COORD_BITS(COORD_BITS)) u_match (
    .qx    (q_x_r),
    .qy    (q_y_r),
    .qz    (q_z_r),
    .level (rd_level),
    .kx    (rd_x),
    .ky    (rd_y),
    .kz    (rd_z),
    .hit   (hit)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    iss_nxt       = iss_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    rd_vld_nxt    = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          res_nxt   = '0;
          state_nxt = S_FIN;
          case (mcpl_pkg::cmd_t'(in_command))
            mcpl_pkg::CMD_CLEAR: begin
              cnt_nxt = '0;
            end
            mcpl_pkg::CMD_LOAD: begin
              if (full) begin
                res_nxt.status = mcpl_pkg::STATUS_FULL;
              end else begin
                res_nxt.index = mcpl_pkg::PINDEX_W'(cnt_r[AW-1:0]);
                cnt_nxt       = cnt_r + CNT_W'(1);
              end
            end
            mcpl_pkg::CMD_LOOKUP: begin
              iss_nxt = '0;
              if (cnt_r != '0) begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        rd_vld_nxt = 1'b1;
        if (last_iss) begin
          state_nxt = S_DRAIN;
        end else begin
          iss_nxt = iss_r + AW'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_res_nxt   = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // finer cell wins; on equal level the earlier slot stays
    if (rd_vld_r && hit && (!res_r.found || (rd_level > res_r.level))) begin
      res_nxt.found = 1'b1;
      res_nxt.value = rd_value;
      res_nxt.level = rd_level;
      res_nxt.index = mcpl_pkg::PINDEX_W'(rd_idx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      centre_r    <= 1'b0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= rd_vld_nxt;
      if (cfg_we) begin
        centre_r <= cfg_wdata;
      end
    end
    iss_r     <= iss_nxt;
    rd_idx_r  <= iss_r;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
    if (acc) begin
      q_x_r <= in_x;
      q_y_r <= in_y;
      q_z_r <= in_z;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_res_r.status;
  assign out_found       = out_res_r.found;
  assign out_found_value = out_res_r.value;
  assign out_found_level = out_res_r.level;
  assign out_entry_index = out_res_r.index;

  `MCPL_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= CNT_FULL, "fill count beyond table depth")
  `MCPL_ASSERT(a_out_from_fin, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == S_FIN),
    "result raised outside finish state")
  `MCPL_ASSERT(a_rd_in_scan, clk, rst_n,
    rd_vld_r |-> (state_r == S_SCAN || state_r == S_DRAIN), "read data outside scan")
  `MCPL_ASSERT(a_full_no_grow, clk, rst_n,
    (acc && full && (mcpl_pkg::cmd_t'(in_command) == mcpl_pkg::CMD_LOAD)) |=>
    (cnt_r == $past(cnt_r)), "refused load changed the fill count")

endmodule
